/* rtl/core/mcsc_pkg.sv */
// mcsc_pkg: shared types, codes and helper functions of the MQTT client
// session controller. Used by every module of the block; depends on nothing.
`default_nettype none

package mcsc_pkg;

  // event codes of an input transaction
  localparam logic [3:0] OP_CONNECT    = 4'd0;
  localparam logic [3:0] OP_TCP_UP     = 4'd1;
  localparam logic [3:0] OP_ACKED      = 4'd2;
  localparam logic [3:0] OP_RX         = 4'd3;
  localparam logic [3:0] OP_CLOSED     = 4'd4;
  localparam logic [3:0] OP_REXMIT     = 4'd5;
  localparam logic [3:0] OP_POLL       = 4'd6;
  localparam logic [3:0] OP_TICK       = 4'd7;
  localparam logic [3:0] OP_PUBLISH    = 4'd8;
  localparam logic [3:0] OP_SUBSCRIBE  = 4'd9;
  localparam logic [3:0] OP_DISCONNECT = 4'd10;

  // session states
  localparam logic [3:0] ST_DISC          = 4'd0;
  localparam logic [3:0] ST_WAIT          = 4'd1;
  localparam logic [3:0] ST_CONNECTING    = 4'd2;
  localparam logic [3:0] ST_CONN_SENT     = 4'd3;
  localparam logic [3:0] ST_CONNECTED     = 4'd4;
  localparam logic [3:0] ST_PUBLISHING    = 4'd5;
  localparam logic [3:0] ST_SUBSCRIBING   = 4'd6;
  localparam logic [3:0] ST_SUB_SENT      = 4'd7;
  localparam logic [3:0] ST_PINGING       = 4'd8;
  localparam logic [3:0] ST_DISCONNECTING = 4'd9;

  // packet types to send
  localparam logic [2:0] TX_NONE       = 3'd0;
  localparam logic [2:0] TX_CONNECT    = 3'd1;
  localparam logic [2:0] TX_PUBLISH    = 3'd2;
  localparam logic [2:0] TX_SUBSCRIBE  = 3'd3;
  localparam logic [2:0] TX_PINGREQ    = 3'd4;
  localparam logic [2:0] TX_DISCONNECT = 3'd5;

  // connection commands
  localparam logic [1:0] CL_NONE  = 2'd0;
  localparam logic [1:0] CL_CLOSE = 2'd1;
  localparam logic [1:0] CL_ABORT = 2'd2;

  // received packet type nibbles
  localparam logic [3:0] RX_CONNACK  = 4'd2;
  localparam logic [3:0] RX_PUBLISH  = 4'd3;
  localparam logic [3:0] RX_SUBACK   = 4'd9;
  localparam logic [3:0] RX_PINGRESP = 4'd13;

  localparam logic [15:0] KA_SECS_RESET = 16'd15;
  localparam logic [15:0] KA_SECS_GUARD = 16'd2;
  localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

  typedef struct packed {
    logic [3:0] op;
    logic [3:0] rx_type;
    logic [7:0] connack_code;
    logic [6:0] publish_length;
    logic       publish_retain_flag;
  } item_t;

  typedef struct packed {
    logic [2:0]  tx_packet;
    logic [1:0]  close_action;
    logic [3:0]  session_state;
    logic        is_connected;
    logic [7:0]  last_error;
    logic [15:0] sub_message_id;
    logic        retain_out;
    logic        deliver_publish;
    logic        last;
  } result_t;

  // session states that count as connected
  function automatic logic is_conn(input logic [3:0] st);
    is_conn = (st == ST_CONNECTED) || (st == ST_PUBLISHING) ||
              (st == ST_SUBSCRIBING) || (st == ST_SUB_SENT) ||
              (st == ST_PINGING);
  endfunction

  // packet that goes with a session state
  function automatic logic [2:0] pkt_for_state(input logic [3:0] st);
    case (st)
      ST_CONNECTING:    pkt_for_state = TX_CONNECT;
      ST_PUBLISHING:    pkt_for_state = TX_PUBLISH;
      ST_SUBSCRIBING:   pkt_for_state = TX_SUBSCRIBE;
      ST_PINGING:       pkt_for_state = TX_PINGREQ;
      ST_DISCONNECTING: pkt_for_state = TX_DISCONNECT;
      default:          pkt_for_state = TX_NONE;
    endcase
  endfunction

endpackage

`default_nettype wire

/* rtl/core/mqtt_client_session_controller_unit.sv */
// mqtt_client_session_controller_unit: top level of the MQTT client session
// controller. Depends on mcsc_pkg, mcsc_step and mcsc_out_stage.
//
// Usage:
//   Input channel (in_valid / in_stall): one event per transaction (op plus
//   rx_type, connack_code, publish_length, publish_retain_flag).
//   Output channel (out_valid / out_stall): one or two results per event;
//   out_last marks the final result of an event. The second result appears
//   only when the keep-alive check fires (DISCONNECT or abort).
//   Config: cfg_we writes cfg_wdata into keep_alive_seconds (reset 15);
//   write only while the block is idle.
// Timing:
//   An accepted event is processed from the input register; its first result
//   is then offered from the result register. One event per cycle is sustained
//   while each event gives one result and out_stall stays low; a second result
//   holds the input while the hold register drains.
// Reset: synchronous, active low; session returns to disconnected, all
//   flags and counters clear, keep-alive returns to 15, no result is valid.
// Stall: a stalled result holds steady; the input register then fills and
//   in_stall rises until the output slot frees.
`default_nettype none

module mqtt_client_session_controller_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_op,
  input  wire logic [3:0]  in_rx_type,
  input  wire logic [7:0]  in_connack_code,
  input  wire logic [6:0]  in_publish_length,
  input  wire logic        in_publish_retain_flag,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_tx_packet,
  output logic [1:0]       out_close_action,
  output logic [3:0]       out_session_state,
  output logic             out_is_connected,
  output logic [7:0]       out_last_error,
  output logic [15:0]      out_sub_message_id,
  output logic             out_retain_out,
  output logic             out_deliver_publish,
  output logic             out_last
);

  logic [15:0]       ka_secs_r;
  logic              in_valid_r;
  mcsc_pkg::item_t   item_r;
  logic              can_push;
  logic              fire;
  mcsc_pkg::result_t res0;
  mcsc_pkg::result_t res1;
  logic              two_results;
  mcsc_pkg::result_t out_res;

  // keep-alive configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ka_secs_r <= mcsc_pkg::KA_SECS_RESET;
    end else if (cfg_we) begin
      ka_secs_r <= cfg_wdata;
    end
  end

  // input register: loads when empty or processed this cycle
  assign fire     = in_valid_r && can_push;
  assign in_stall = in_valid_r && !can_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.op                  <= in_op;
      item_r.rx_type             <= in_rx_type;
      item_r.connack_code        <= in_connack_code;
      item_r.publish_length      <= in_publish_length;
      item_r.publish_retain_flag <= in_publish_retain_flag;
    end
  end

  // session update
  mcsc_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .item        (item_r),
    .ka_secs     (ka_secs_r),
    .res0        (res0),
    .res1        (res1),
    .two_results (two_results)
  );

  // result registers
  mcsc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .push_two  (two_results),
    .push_res0 (res0),
    .push_res1 (res1),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_tx_packet       = out_res.tx_packet;
  assign out_close_action    = out_res.close_action;
  assign out_session_state   = out_res.session_state;
  assign out_is_connected    = out_res.is_connected;
  assign out_last_error      = out_res.last_error;
  assign out_sub_message_id  = out_res.sub_message_id;
  assign out_retain_out      = out_res.retain_out;
  assign out_deliver_publish = out_res.deliver_publish;
  assign out_last            = out_res.last;

endmodule

`default_nettype wire

/* rtl/core/mcsc_step.sv */
// mcsc_step: session state registers and the per-event update logic.
// Produces up to two results per event. Depends on mcsc_pkg.
`default_nettype none

module mcsc_step (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire mcsc_pkg::item_t  item,
  input  wire logic [15:0]      ka_secs,
  output mcsc_pkg::result_t     res0,
  output mcsc_pkg::result_t     res1,
  output logic                  two_results
);

  logic [3:0]  session_r, session_nxt;
  logic        pub_r, pub_nxt;
  logic        ret_r, ret_nxt;
  logic        sub_r, sub_nxt;
  logic        ping_r, ping_nxt;
  logic [15:0] msg_r, msg_nxt;
  logic [7:0]  refusal_r, refusal_nxt;
  logic [15:0] tx_idle_r, tx_idle_nxt;
  logic [15:0] rx_idle_r, rx_idle_nxt;

  logic [2:0]  tx, tx2;
  logic [1:0]  cl, cl2;
  logic        dl;
  logic        second;
  logic        check_en;
  logic [15:0] limit;
  logic        expired;
  logic [3:0]  ev_session;

  // event handling, then the keep-alive timeout check
  always_comb begin
    session_nxt = session_r;
    pub_nxt     = pub_r;
    ret_nxt     = ret_r;
    sub_nxt     = sub_r;
    ping_nxt    = ping_r;
    msg_nxt     = msg_r;
    refusal_nxt = refusal_r;
    tx_idle_nxt = tx_idle_r;
    rx_idle_nxt = rx_idle_r;
    tx          = mcsc_pkg::TX_NONE;
    cl          = mcsc_pkg::CL_NONE;
    dl          = 1'b0;
    tx2         = mcsc_pkg::TX_NONE;
    cl2         = mcsc_pkg::CL_NONE;
    second      = 1'b0;

    case (item.op)
      mcsc_pkg::OP_CONNECT: begin
        session_nxt = mcsc_pkg::ST_WAIT;
        tx_idle_nxt = '0;
        rx_idle_nxt = '0;
      end
      mcsc_pkg::OP_TCP_UP: begin
        session_nxt = mcsc_pkg::ST_CONNECTING;
        tx          = mcsc_pkg::TX_CONNECT;
        tx_idle_nxt = '0;
      end
      mcsc_pkg::OP_ACKED: begin
        case (session_r)
          mcsc_pkg::ST_CONNECTING: session_nxt = mcsc_pkg::ST_CONN_SENT;
          mcsc_pkg::ST_PUBLISHING: begin
            session_nxt = mcsc_pkg::ST_CONNECTED;
            pub_nxt     = 1'b0;
          end
          mcsc_pkg::ST_PINGING: begin
            session_nxt = mcsc_pkg::ST_CONNECTED;
            ping_nxt    = 1'b0;
          end
          mcsc_pkg::ST_SUBSCRIBING: begin
            session_nxt = mcsc_pkg::ST_SUB_SENT;
            sub_nxt     = 1'b0;
          end
          mcsc_pkg::ST_DISCONNECTING: begin
            session_nxt = mcsc_pkg::ST_DISC;
            cl          = mcsc_pkg::CL_CLOSE;
          end
          default: ;
        endcase
      end
      mcsc_pkg::OP_RX: begin
        if (item.rx_type == mcsc_pkg::RX_CONNACK) begin
          if (item.connack_code == 8'd0) begin
            session_nxt = mcsc_pkg::ST_CONNECTED;
          end else begin
            cl          = mcsc_pkg::CL_CLOSE;
            session_nxt = mcsc_pkg::ST_DISC;
            refusal_nxt = item.connack_code;
          end
        end else if (item.rx_type == mcsc_pkg::RX_SUBACK) begin
          session_nxt = mcsc_pkg::ST_CONNECTED;
        end else if (item.rx_type == mcsc_pkg::RX_PINGRESP) begin
          ping_nxt = 1'b0;
        end else if (item.rx_type == mcsc_pkg::RX_PUBLISH) begin
          dl = 1'b1;
        end
        rx_idle_nxt = '0;
      end
      mcsc_pkg::OP_CLOSED: begin
        session_nxt = mcsc_pkg::ST_DISC;
        cl          = mcsc_pkg::CL_CLOSE;
      end
      mcsc_pkg::OP_REXMIT: begin
        tx = mcsc_pkg::pkt_for_state(session_r);
        if (tx != mcsc_pkg::TX_NONE) begin
          tx_idle_nxt = '0;
        end
      end
      mcsc_pkg::OP_POLL: begin
        if (session_r == mcsc_pkg::ST_CONNECTED) begin
          if (pub_r) begin
            session_nxt = mcsc_pkg::ST_PUBLISHING;
            tx          = mcsc_pkg::TX_PUBLISH;
            tx_idle_nxt = '0;
          end else if (sub_r) begin
            session_nxt = mcsc_pkg::ST_SUBSCRIBING;
            msg_nxt     = msg_r + 16'd1;
            tx          = mcsc_pkg::TX_SUBSCRIBE;
            tx_idle_nxt = '0;
          end else if (ping_r) begin
            session_nxt = mcsc_pkg::ST_PINGING;
            tx          = mcsc_pkg::TX_PINGREQ;
            tx_idle_nxt = '0;
          end
        end
      end
      mcsc_pkg::OP_TICK: begin
        if (tx_idle_r != mcsc_pkg::IDLE_MAX) begin
          tx_idle_nxt = tx_idle_r + 16'd1;
        end
        if (rx_idle_r != mcsc_pkg::IDLE_MAX) begin
          rx_idle_nxt = rx_idle_r + 16'd1;
        end
      end
      mcsc_pkg::OP_PUBLISH: begin
        pub_nxt = (item.publish_length != 7'd0);
        ret_nxt = item.publish_retain_flag;
      end
      mcsc_pkg::OP_SUBSCRIBE: sub_nxt = 1'b1;
      mcsc_pkg::OP_DISCONNECT: begin
        if (mcsc_pkg::is_conn(session_r)) begin
          session_nxt = mcsc_pkg::ST_DISCONNECTING;
          tx          = mcsc_pkg::TX_DISCONNECT;
          tx_idle_nxt = '0;
        end
      end
      default: ;
    endcase

    // keep-alive timeout check on connection events and ticks
    ev_session = session_nxt;
    check_en   = (item.op >= mcsc_pkg::OP_TCP_UP) && (item.op <= mcsc_pkg::OP_TICK) &&
                 (ev_session != mcsc_pkg::ST_DISC);
    limit      = ka_secs - mcsc_pkg::KA_SECS_GUARD;
    expired    = (tx_idle_nxt >= limit) || (rx_idle_nxt >= limit);
    if (check_en && expired) begin
      if (mcsc_pkg::is_conn(ev_session)) begin
        if (!ping_nxt) begin
          ping_nxt    = 1'b1;
          rx_idle_nxt = '0;
          tx_idle_nxt = '0;
        end else begin
          session_nxt = mcsc_pkg::ST_DISCONNECTING;
          tx2         = mcsc_pkg::TX_DISCONNECT;
          tx_idle_nxt = '0;
          second      = 1'b1;
        end
      end else begin
        session_nxt = mcsc_pkg::ST_DISC;
        cl2         = mcsc_pkg::CL_ABORT;
        second      = 1'b1;
      end
    end
  end

  // result assembly: both results report the final session
  always_comb begin
    res0.tx_packet       = tx;
    res0.close_action    = cl;
    res0.session_state   = session_nxt;
    res0.is_connected    = mcsc_pkg::is_conn(session_nxt);
    res0.last_error      = refusal_nxt;
    res0.sub_message_id  = (tx == mcsc_pkg::TX_SUBSCRIBE) ? msg_nxt : 16'd0;
    res0.retain_out      = (tx == mcsc_pkg::TX_PUBLISH) ? ret_nxt : 1'b0;
    res0.deliver_publish = dl;
    res0.last            = !second;

    res1.tx_packet       = tx2;
    res1.close_action    = cl2;
    res1.session_state   = session_nxt;
    res1.is_connected    = mcsc_pkg::is_conn(session_nxt);
    res1.last_error      = refusal_nxt;
    res1.sub_message_id  = 16'd0;
    res1.retain_out      = 1'b0;
    res1.deliver_publish = 1'b0;
    res1.last            = 1'b1;
  end

  assign two_results = second;

  // session registers, updated once per processed transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_r <= mcsc_pkg::ST_DISC;
      pub_r     <= 1'b0;
      ret_r     <= 1'b0;
      sub_r     <= 1'b0;
      ping_r    <= 1'b0;
      msg_r     <= '0;
      refusal_r <= '0;
      tx_idle_r <= '0;
      rx_idle_r <= '0;
    end else if (fire) begin
      session_r <= session_nxt;
      pub_r     <= pub_nxt;
      ret_r     <= ret_nxt;
      sub_r     <= sub_nxt;
      ping_r    <= ping_nxt;
      msg_r     <= msg_nxt;
      refusal_r <= refusal_nxt;
      tx_idle_r <= tx_idle_nxt;
      rx_idle_r <= rx_idle_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mcsc_out_stage.sv */
// mcsc_out_stage: result register plus a hold register for the second
// result of an event. Depends on mcsc_pkg.
`default_nettype none

module mcsc_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire logic               push_two,
  input  wire mcsc_pkg::result_t  push_res0,
  input  wire mcsc_pkg::result_t  push_res1,
  output logic                    can_push,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output mcsc_pkg::result_t       out_res
);

  logic              out_valid_r;
  mcsc_pkg::result_t out_r;
  logic              hold_valid_r;
  mcsc_pkg::result_t hold_r;
  logic              out_free;

  // output slot frees when empty or taken this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign can_push  = out_free && !hold_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // control: valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else if (out_free) begin
      if (hold_valid_r) begin
        out_valid_r  <= 1'b1;
        hold_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= push;
        hold_valid_r <= push && push_two;
      end
    end
  end

  // payload: second result drains through the hold register
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (hold_valid_r) begin
        out_r <= hold_r;
      end else if (push) begin
        out_r  <= push_res0;
        hold_r <= push_res1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mcsc_checker.sv */
// mcsc_checker: port-level assertions for the session controller top level,
// bound to mqtt_client_session_controller_unit. Depends on mcsc_pkg.
`default_nettype none

module mcsc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_tx_packet,
  input wire logic [1:0]  out_close_action,
  input wire logic [3:0]  out_session_state,
  input wire logic        out_is_connected,
  input wire logic [15:0] out_sub_message_id,
  input wire logic        out_last
);

  // no result is offered right after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled transaction holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_tx_packet) &&
    $stable(out_session_state) && $stable(out_last))
    else $error("stalled result changed");

  // connected flag follows the reported state
  a_conn_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_is_connected ==
      ((out_session_state == mcsc_pkg::ST_CONNECTED) ||
       (out_session_state == mcsc_pkg::ST_PUBLISHING) ||
       (out_session_state == mcsc_pkg::ST_SUBSCRIBING) ||
       (out_session_state == mcsc_pkg::ST_SUB_SENT) ||
       (out_session_state == mcsc_pkg::ST_PINGING)))
    else $error("is_connected inconsistent with state");

  // message id only rides on a SUBSCRIBE
  a_msg_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_tx_packet != mcsc_pkg::TX_SUBSCRIBE) |->
      out_sub_message_id == 16'd0)
    else $error("message id without SUBSCRIBE");

  // an abort always leaves the session disconnected and is the last result of its event
  a_abort_disc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_close_action == mcsc_pkg::CL_ABORT) |->
      out_session_state == mcsc_pkg::ST_DISC && out_last)
    else $error("abort without disconnect");

endmodule

bind mqtt_client_session_controller_unit mcsc_checker u_mcsc_checker (.*);

`default_nettype wire
